// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LPH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define LPH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/lph_pkg.sv -----
// ----------------------------------------------------------------------------
// lph_pkg
// Shared constants, command and status codes, and the hash step function.
// ----------------------------------------------------------------------------
package lph_pkg;

	localparam int unsigned SLOTS_DEF       = 256;
	localparam int unsigned KEY_BYTES_DEF   = 8;
	localparam int unsigned VALUE_BYTES_DEF = 8;

	localparam int unsigned HASH_W     = 32;
	localparam int unsigned HASH_SHIFT = 5;  // 33*h = (h << 5) + h

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_FETCH  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
		input logic [7:0] b);
		logic [HASH_W-1:0] mul;
		mul = (h << HASH_SHIFT) + h;
		return mul ^ {{(HASH_W-8){b[7]}}, b};
	endfunction

endpackage

// ----- src/lph_ram.sv -----
// ----------------------------------------------------------------------------
// lph_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lph_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing over one slot RAM.
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | cmd, key_bytes, key_len, new_value,
//          |                      | new_value_len
//  out     | out_valid / out_ready| found, value_out, value_len_out, status
//
//  Insert/fetch: accept, hash over the key bytes, the modulo steps (quotient
//    estimate, remainder, correction), slot probes, then the output word.
//  Clear: one RAM row per cycle over all SLOTS rows, then the output word.
//  After reset a clearing pass over all SLOTS rows runs; in_ready stays low.
//  One word in flight; a new word is taken while the output word waits.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
	parameter int unsigned SLOTS       = lph_pkg::SLOTS_DEF,
	parameter int unsigned KEY_BYTES   = lph_pkg::KEY_BYTES_DEF,
	parameter int unsigned VALUE_BYTES = lph_pkg::VALUE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_len,
	input  logic [63:0] new_value,
	input  logic [3:0]  new_value_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [63:0] value_out,
	output logic [3:0]  value_len_out,
	output logic        status
);
	import lph_pkg::*;

	localparam int unsigned AW        = $clog2(SLOTS);
	localparam int unsigned KW        = 8 * KEY_BYTES;
	localparam int unsigned VW        = 8 * VALUE_BYTES;
	localparam int unsigned LW        = 4;
	localparam int unsigned KIW       = $clog2(KEY_BYTES + 1);
	localparam int unsigned CW        = $clog2(SLOTS / 2 + 1);
	localparam int unsigned EW        = 1 + LW + KW + LW + VW;
	localparam int unsigned REC_SHIFT = HASH_W - 1 + AW;

	localparam logic [AW:0]     SLOTS_X   = (AW + 1)'(SLOTS);
	localparam logic [HASH_W-1:0] SLOTS_W = HASH_W'(SLOTS);
	localparam logic [HASH_W-1:0] REC_MUL = HASH_W'((64'd1 << REC_SHIFT) / 64'(SLOTS));
	localparam logic [AW-1:0]   LAST      = AW'(SLOTS - 1);
	localparam logic [CW-1:0]   HALF      = CW'(SLOTS / 2);
	localparam logic [1:0]      MSTEP_REM = 2'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_PROBE,
		ST_RESP
	} state_t;

	state_t             state_q;
	logic               clr_resp_q;
	logic [AW-1:0]      clr_idx_q;
	logic [CW-1:0]      count_q;
	logic [1:0]         cmd_q;
	logic [KW-1:0]      key_q;
	logic [LW-1:0]      klen_q;
	logic [VW-1:0]      val_q;
	logic [LW-1:0]      vlen_q;
	logic [KIW-1:0]     idx_q;
	logic [HASH_W-1:0]  h_q;
	logic [HASH_W-1:0]  qe_q;
	logic [AW:0]        rem_q;
	logic [1:0]         mstep_q;
	logic [AW-1:0]      pos_q;
	logic               res_found_q;
	logic [VW-1:0]      res_val_q;
	logic [LW-1:0]      res_vlen_q;
	logic               res_status_q;
	logic               out_valid_q;
	logic               found_q;
	logic [VW-1:0]      value_q;
	logic [LW-1:0]      value_len_q;
	logic               status_q;

	// accept-side clamping and masking
	logic [LW-1:0] klen_c;
	logic [LW-1:0] vlen_c;
	logic [KW-1:0] key_m;
	logic [VW-1:0] val_m;

	always_comb begin
		klen_c = (key_len > LW'(KEY_BYTES)) ? LW'(KEY_BYTES) : key_len;
		vlen_c = (new_value_len > LW'(VALUE_BYTES)) ? LW'(VALUE_BYTES) : new_value_len;
		for (int i = 0; i < KEY_BYTES; i++) begin
			key_m[8*i +: 8] = (LW'(i) < klen_c) ? key_bytes[8*i +: 8] : 8'd0;
		end
		for (int i = 0; i < VALUE_BYTES; i++) begin
			val_m[8*i +: 8] = (LW'(i) < vlen_c) ? new_value[8*i +: 8] : 8'd0;
		end
	end

	// hash byte, last byte first
	logic [KIW+2:0] hsh;
	logic [7:0]     hbyte;

	assign hsh   = {KIW'(idx_q - 1'b1), 3'b000};
	assign hbyte = 8'(key_q >> hsh);

	// remainder by reciprocal multiply: quotient estimate, then one correction
	logic [2*HASH_W-1:0] qe_prod;
	logic [HASH_W-1:0]   qe_nxt;
	logic [HASH_W-1:0]   qd;
	logic [HASH_W-1:0]   rem_full;
	logic [AW:0]         rem_nxt;
	logic [AW-1:0]       r_nxt;

	assign qe_prod  = (2*HASH_W)'(h_q) * (2*HASH_W)'(REC_MUL);
	assign qe_nxt   = HASH_W'(qe_prod >> REC_SHIFT);
	assign qd       = qe_q * SLOTS_W;
	assign rem_full = h_q - qd;
	assign rem_nxt  = rem_full[AW:0];
	assign r_nxt    = (rem_q >= SLOTS_X) ? AW'(rem_q - SLOTS_X) : rem_q[AW-1:0];

	logic [AW-1:0] pos_nxt;

	assign pos_nxt = (pos_q == LAST) ? '0 : pos_q + 1'b1;

	// slot RAM: {valid, key_len, key, value_len, value}
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic          e_valid;
	logic [LW-1:0] e_klen;
	logic [KW-1:0] e_key;
	logic [LW-1:0] e_vlen;
	logic [VW-1:0] e_val;
	logic          e_match;
	logic          ins_hit;

	assign e_valid = ram_rdata[EW-1];
	assign e_klen  = ram_rdata[EW-2 -: LW];
	assign e_key   = ram_rdata[EW-2-LW -: KW];
	assign e_vlen  = ram_rdata[VW+LW-1 -: LW];
	assign e_val   = ram_rdata[VW-1:0];
	assign e_match = e_valid && (e_klen == klen_q) && (e_key == key_q);
	assign ins_hit = (state_q == ST_PROBE) && !e_valid && (cmd_q == CMD_INSERT);

	always_comb begin
		ram_we    = (state_q == ST_CLEAR) || ins_hit;
		ram_waddr = (state_q == ST_CLEAR) ? clr_idx_q : pos_q;
		ram_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, klen_q, key_q, vlen_q, val_q};
		case (state_q)
			ST_MOD:   ram_raddr = r_nxt;
			ST_PROBE: ram_raddr = pos_nxt;
			default:  ram_raddr = pos_q;
		endcase
	end

	lph_ram #(
		.WIDTH (EW),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_resp_q  <= 1'b0;
			clr_idx_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q        <= cmd;
						key_q        <= key_m;
						klen_q       <= klen_c;
						val_q        <= val_m;
						vlen_q       <= vlen_c;
						idx_q        <= KIW'(klen_c);
						h_q          <= '0;
						res_found_q  <= 1'b0;
						res_val_q    <= '0;
						res_vlen_q   <= '0;
						res_status_q <= STATUS_DONE;
						case (cmd)
							CMD_INSERT: begin
								if (count_q >= HALF) begin
									res_status_q <= STATUS_FULL;
									state_q      <= ST_RESP;
								end else begin
									state_q <= ST_HASH;
								end
							end
							CMD_FETCH: begin
								state_q <= ST_HASH;
							end
							CMD_CLEAR: begin
								clr_resp_q <= 1'b1;
								clr_idx_q  <= '0;
								state_q    <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_HASH: begin
					if (idx_q == '0) begin
						mstep_q <= '0;
						state_q <= ST_MOD;
					end else begin
						h_q   <= hash_step(h_q, hbyte);
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_MOD: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == '0) begin
						qe_q <= qe_nxt;
					end else if (mstep_q == MSTEP_REM) begin
						rem_q <= rem_nxt;
					end else begin
						pos_q   <= r_nxt;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (!e_valid) begin
						if (cmd_q == CMD_INSERT) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_RESP;
					end else if (cmd_q == CMD_FETCH && e_match) begin
						res_found_q <= 1'b1;
						res_val_q   <= e_val;
						res_vlen_q  <= e_vlen;
						state_q     <= ST_RESP;
					end else begin
						pos_q <= pos_nxt;
					end
				end
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST) begin
						count_q    <= '0;
						clr_resp_q <= 1'b0;
						state_q    <= clr_resp_q ? ST_RESP : ST_IDLE;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						found_q     <= res_found_q;
						value_q     <= res_val_q;
						value_len_q <= res_vlen_q;
						status_q    <= res_status_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign value_out     = 64'(value_q);
	assign value_len_out = value_len_q;
	assign status        = status_q;

endmodule

// ----- src/lph_checker.sv -----
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks for linear_probe_hash_table, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lph_checker #(
	parameter int unsigned VALUE_BYTES = lph_pkg::VALUE_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [63:0] value_out,
	input logic [3:0]  value_len_out,
	input logic        status
);
	import lph_pkg::*;

	`LPH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(value_out) && $stable(value_len_out) && $stable(status), "output word changed while stalled")
	`LPH_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid && !found, value_out == 64'd0 && value_len_out == 4'd0, "value returned without a hit")
	`LPH_ASSERT_IMP(a_hit_ok, clk, arst_n, out_valid && found, status == STATUS_DONE && value_len_out <= 4'(VALUE_BYTES), "bad hit word")
	`LPH_ASSERT_NXT(a_one_word, clk, arst_n, in_valid && in_ready, !in_ready, "second word taken while busy")

endmodule

bind linear_probe_hash_table lph_checker #(
	.VALUE_BYTES (VALUE_BYTES)
) u_lph_checker (.*);
